[sv/irpfd_pkg.sv]
// Shared types and constants for the IR pulse frame decoder.
// No dependencies; every other file in this folder but irpfd_window.sv uses it by scoped name.
package irpfd_pkg;

	// Register file layout
	localparam int NUM_REGS  = 7;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LEADER_HIGH = 3'd0,
		REG_LEADER_LOW  = 3'd1,
		REG_BIT_HIGH    = 3'd2,
		REG_ZERO_LOW    = 3'd3,
		REG_ONE_LOW     = 3'd4,
		REG_STOP_HIGH   = 3'd5,
		REG_MARGIN      = 3'd6
	} reg_idx_t;

	// Reset values, cut down to the tick width at the register file
	localparam logic [31:0] REG_RESET [NUM_REGS] = '{
		32'd9000, 32'd4500, 32'd560, 32'd560, 32'd1690, 32'd560, 32'd200
	};

	// Byte assembly
	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_POS_W     = $clog2(BITS_PER_BYTE);

	// Frame phase; code 3 is unused and behaves as frame ended
	typedef enum logic [1:0] {
		PH_LEADER = 2'd0,
		PH_FRAME  = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_OK   = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// Window compare hits for one symbol
	typedef struct packed {
		logic lead_hi;
		logic lead_lo;
		logic stop_hi;
		logic bit_hi;
		logic one_lo;
		logic zero_lo;
	} hit_t;

	// One result beat
	typedef struct packed {
		kind_t                    kind;
		logic [BITS_PER_BYTE-1:0] byte_val;
		logic                     run_last;
	} result_t;

	// Output queue sizing
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

endpackage

[sv/ir_pulse_frame_decoder.sv]
// IR pulse frame decoder: leader, data bits LSB first, stop; bytes and status out.
// An input beat passes the input register stage and then the result queue before its results go out.
// Throughput: one symbol per cycle while the result queue has room; a symbol with two results gives two output beats.
// Input stalls while a symbol waits and the 4-entry result queue holds more than 2 entries.
// Reset (arst_n low, async): leader phase, bits cleared, timing registers to defaults.
module ir_pulse_frame_decoder #(
	parameter int TICK_WIDTH = 15,
	localparam int S_DATA_W  = ((2 * TICK_WIDTH + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// symbol in
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [S_DATA_W-1:0]                  s_tdata,  // high_ticks, low_ticks, zero pad
	input  logic                                 s_tlast,  // capture_last
	// result out
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [irpfd_pkg::BITS_PER_BYTE-1:0]  m_tdata,  // byte_value
	output logic [1:0]                           m_tuser,  // result_kind
	output logic                                 m_tlast,  // run_last
	// register writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [irpfd_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [TICK_WIDTH-1:0]                cfg_data
);

	logic [irpfd_pkg::NUM_REGS-1:0][TICK_WIDTH-1:0] cfg_regs;

	logic                   valid_s1;
	logic [TICK_WIDTH-1:0]  hi_s1;
	logic [TICK_WIDTH-1:0]  lo_s1;
	logic                   last_s1;
	logic                   advance;
	logic                   room;

	irpfd_pkg::hit_t        hit;
	logic [1:0]             push_cnt;
	irpfd_pkg::result_t     res0, res1, head;

	assign cfg_ready = 1'b1;

	irpfd_cfg #(.TICK_WIDTH(TICK_WIDTH)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs_q   (cfg_regs)
	);

	// Input register stage
	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hi_s1   <= s_tdata[TICK_WIDTH-1:0];
			lo_s1   <= s_tdata[2*TICK_WIDTH-1:TICK_WIDTH];
			last_s1 <= s_tlast;
		end
	end

	// Window compares, all in parallel
	irpfd_window #(.TICK_WIDTH(TICK_WIDTH)) u_win_lead_hi (
		.dur     (hi_s1),
		.nominal (cfg_regs[irpfd_pkg::REG_LEADER_HIGH]),
		.margin  (cfg_regs[irpfd_pkg::REG_MARGIN]),
		.hit     (hit.lead_hi)
	);
	irpfd_window #(.TICK_WIDTH(TICK_WIDTH)) u_win_lead_lo (
		.dur     (lo_s1),
		.nominal (cfg_regs[irpfd_pkg::REG_LEADER_LOW]),
		.margin  (cfg_regs[irpfd_pkg::REG_MARGIN]),
		.hit     (hit.lead_lo)
	);
	irpfd_window #(.TICK_WIDTH(TICK_WIDTH)) u_win_stop_hi (
		.dur     (hi_s1),
		.nominal (cfg_regs[irpfd_pkg::REG_STOP_HIGH]),
		.margin  (cfg_regs[irpfd_pkg::REG_MARGIN]),
		.hit     (hit.stop_hi)
	);
	irpfd_window #(.TICK_WIDTH(TICK_WIDTH)) u_win_bit_hi (
		.dur     (hi_s1),
		.nominal (cfg_regs[irpfd_pkg::REG_BIT_HIGH]),
		.margin  (cfg_regs[irpfd_pkg::REG_MARGIN]),
		.hit     (hit.bit_hi)
	);
	irpfd_window #(.TICK_WIDTH(TICK_WIDTH)) u_win_one_lo (
		.dur     (lo_s1),
		.nominal (cfg_regs[irpfd_pkg::REG_ONE_LOW]),
		.margin  (cfg_regs[irpfd_pkg::REG_MARGIN]),
		.hit     (hit.one_lo)
	);
	irpfd_window #(.TICK_WIDTH(TICK_WIDTH)) u_win_zero_lo (
		.dur     (lo_s1),
		.nominal (cfg_regs[irpfd_pkg::REG_ZERO_LOW]),
		.margin  (cfg_regs[irpfd_pkg::REG_MARGIN]),
		.hit     (hit.zero_lo)
	);

	// Frame decode
	irpfd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_last  (last_s1),
		.hit      (hit),
		.push_cnt (push_cnt),
		.res0     (res0),
		.res1     (res1)
	);

	// Result queue
	irpfd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_d0   (res0),
		.push_d1   (res1),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.head      (head)
	);

	assign m_tdata = head.byte_val;
	assign m_tuser = head.kind;
	assign m_tlast = head.run_last;

endmodule

[sv/irpfd_cfg.sv]
// Timing register file of the IR pulse frame decoder.
// Depends on irpfd_pkg for register count and reset values.
module irpfd_cfg #(
	parameter int TICK_WIDTH = 15
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  wr_en,
	input  logic [irpfd_pkg::REG_IDX_W-1:0]                       wr_index,
	input  logic [TICK_WIDTH-1:0]                                 wr_data,
	output logic [irpfd_pkg::NUM_REGS-1:0][TICK_WIDTH-1:0]        regs_q
);

	// Write one register per beat; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < irpfd_pkg::NUM_REGS; i++) begin
				regs_q[i] <= irpfd_pkg::REG_RESET[i][TICK_WIDTH-1:0];
			end
		end else if (wr_en) begin
			for (int i = 0; i < irpfd_pkg::NUM_REGS; i++) begin
				if (wr_index == irpfd_pkg::REG_IDX_W'(i)) begin
					regs_q[i] <= wr_data;
				end
			end
		end
	end

endmodule

[sv/irpfd_window.sv]
// Tolerance window compare: strict nominal +/- margin, no hit if margin > nominal.
// Standalone; no package use.
module irpfd_window #(
	parameter int TICK_WIDTH = 15
) (
	input  logic [TICK_WIDTH-1:0] dur,
	input  logic [TICK_WIDTH-1:0] nominal,
	input  logic [TICK_WIDTH-1:0] margin,
	output logic                  hit
);

	logic [TICK_WIDTH-1:0] lo_bound;
	logic [TICK_WIDTH:0]   hi_bound;

	// Lower bound only meaningful when margin <= nominal
	assign lo_bound = nominal - margin;
	assign hi_bound = {1'b0, nominal} + {1'b0, margin};

	assign hit = (margin <= nominal) && (dur > lo_bound) && ({1'b0, dur} < hi_bound);

endmodule

[sv/irpfd_core.sv]
// Frame state machine and byte assembly of the IR pulse frame decoder.
// Depends on irpfd_pkg; takes window hits, gives up to two results per symbol.
module irpfd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                in_last,
	input  irpfd_pkg::hit_t     hit,
	output logic [1:0]          push_cnt,
	output irpfd_pkg::result_t  res0,
	output irpfd_pkg::result_t  res1
);

	localparam int PART_W = irpfd_pkg::BITS_PER_BYTE - 1;

	irpfd_pkg::phase_t                     phase_q, phase_d;
	logic [irpfd_pkg::BIT_POS_W-1:0]       bitpos_q, bitpos_d;
	logic [PART_W-1:0]                     partial_q, partial_d;
	logic [irpfd_pkg::BITS_PER_BYTE-1:0]   set_mask;

	logic                                  a_vld;
	irpfd_pkg::kind_t                      a_kind;
	logic [irpfd_pkg::BITS_PER_BYTE-1:0]   a_val;
	logic                                  b_vld;

	assign set_mask = irpfd_pkg::BITS_PER_BYTE'(1) << bitpos_q;

	// State registers, updated once per symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= irpfd_pkg::PH_LEADER;
			bitpos_q  <= '0;
			partial_q <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			bitpos_q  <= bitpos_d;
			partial_q <= partial_d;
		end
	end

	// Symbol decode: first result from the phase, second from capture end
	always_comb begin
		phase_d   = phase_q;
		bitpos_d  = bitpos_q;
		partial_d = partial_q;
		a_vld     = 1'b0;
		a_kind    = irpfd_pkg::KIND_ERR;
		a_val     = '0;
		b_vld     = 1'b0;

		case (phase_q)
			irpfd_pkg::PH_LEADER: begin
				if (hit.lead_hi && hit.lead_lo) begin
					phase_d   = irpfd_pkg::PH_FRAME;
					bitpos_d  = '0;
					partial_d = '0;
				end else begin
					a_vld   = 1'b1;
					phase_d = irpfd_pkg::PH_DONE;
				end
			end
			irpfd_pkg::PH_FRAME: begin
				if (hit.stop_hi) begin
					// stop is only good on a byte boundary
					a_vld   = 1'b1;
					a_kind  = (bitpos_q == '0) ? irpfd_pkg::KIND_OK : irpfd_pkg::KIND_ERR;
					phase_d = irpfd_pkg::PH_DONE;
				end else if (hit.bit_hi) begin
					if (!hit.one_lo && !hit.zero_lo) begin
						a_vld   = 1'b1;
						phase_d = irpfd_pkg::PH_DONE;
					end else if (bitpos_q == irpfd_pkg::BIT_POS_W'(irpfd_pkg::BITS_PER_BYTE - 1)) begin
						// top bit completes the byte
						a_vld     = 1'b1;
						a_kind    = irpfd_pkg::KIND_BYTE;
						a_val     = {hit.one_lo, partial_q};
						bitpos_d  = '0;
						partial_d = '0;
					end else begin
						if (hit.one_lo) begin
							partial_d = partial_q | set_mask[PART_W-1:0];
						end
						bitpos_d = bitpos_q + 1'b1;
					end
				end else begin
					a_vld   = 1'b1;
					phase_d = irpfd_pkg::PH_DONE;
				end
			end
			default: begin
				// frame ended: ignore until capture end
			end
		endcase

		if (in_last) begin
			b_vld     = (phase_d == irpfd_pkg::PH_FRAME);
			phase_d   = irpfd_pkg::PH_LEADER;
			bitpos_d  = '0;
			partial_d = '0;
		end
	end

	// Result ordering and last marks
	always_comb begin
		res1.kind     = irpfd_pkg::KIND_ERR;
		res1.byte_val = '0;
		res1.run_last = 1'b1;
		if (a_vld) begin
			res0.kind     = a_kind;
			res0.byte_val = a_val;
			res0.run_last = !b_vld;
		end else begin
			res0 = res1;
		end
		push_cnt = advance ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;
	end

`ifndef SYNTH
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && in_last) |=> (phase_q == irpfd_pkg::PH_LEADER))
		else $error("capture end did not return to leader phase");

	a_leader_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == irpfd_pkg::PH_LEADER) |-> (bitpos_q == '0 && partial_q == '0))
		else $error("bits left over while waiting for leader");

	a_pair_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt == 2'd2) |-> (!res0.run_last && res1.run_last))
		else $error("last mark wrong on a result pair");
`endif

endmodule

[sv/irpfd_outq.sv]
// Four-entry result queue: takes up to two results a cycle, gives one a beat.
// Depends on irpfd_pkg for the result type and sizing.
module irpfd_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_cnt,
	input  irpfd_pkg::result_t  push_d0,
	input  irpfd_pkg::result_t  push_d1,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output irpfd_pkg::result_t  head
);

	localparam int PTR_W = irpfd_pkg::OUTQ_PTR_W;
	localparam int CNT_W = irpfd_pkg::OUTQ_CNT_W;

	irpfd_pkg::result_t mem_q [irpfd_pkg::OUTQ_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q, wr_p1;
	logic [CNT_W-1:0]   cnt_q;
	logic               pop;

	assign wr_p1     = wr_q + 1'b1;
	assign pop       = (cnt_q != '0) && out_ready;
	assign out_valid = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	// room for a worst-case pair, ignoring this cycle's pop
	assign room      = (cnt_q <= CNT_W'(irpfd_pkg::OUTQ_DEPTH - 2));

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push_cnt);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < irpfd_pkg::OUTQ_DEPTH; i++) begin
			if (push_cnt != 2'd0 && wr_q == PTR_W'(i)) begin
				mem_q[i] <= push_d0;
			end else if (push_cnt == 2'd2 && wr_p1 == PTR_W'(i)) begin
				mem_q[i] <= push_d1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(irpfd_pkg::OUTQ_DEPTH))
		else $error("result queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> room)
		else $error("results pushed without room for a pair");
`endif

endmodule

[sim/ir_frame_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for ir_pulse_frame_decoder: watches the symbol, register and result
// channels, predicts every result beat and compares it with what the decoder sends.
// Depends on irpfd_pkg.
module ir_frame_result_checker #(
	parameter int TICK_WIDTH = 15,
	localparam int S_DATA_W  = ((2 * TICK_WIDTH + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [S_DATA_W-1:0]                  s_tdata,  // high_ticks, low_ticks, zero pad
	input  logic                                 s_tlast,  // capture_last
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [irpfd_pkg::BITS_PER_BYTE-1:0]  m_tdata,  // byte_value
	input  logic [1:0]                           m_tuser,  // result_kind
	input  logic                                 m_tlast,  // run_last
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [irpfd_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [TICK_WIDTH-1:0]                cfg_data,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   symbols_seen,
	output int                                   bytes_seen,
	output int                                   oks_seen,
	output int                                   errs_seen
);

	// Shadow of the timing registers and of the frame state
	logic [TICK_WIDTH-1:0]               timing [irpfd_pkg::NUM_REGS];
	irpfd_pkg::phase_t                   phase;
	logic [irpfd_pkg::BIT_POS_W-1:0]     bit_pos;
	logic [irpfd_pkg::BITS_PER_BYTE-2:0] partial;

	// Results still owed by the decoder, oldest first
	irpfd_pkg::result_t expected_results [$];
	irpfd_pkg::result_t want;

	// Strictly inside nominal +/- margin; a margin above the nominal never matches
	function automatic logic in_window(input logic [TICK_WIDTH-1:0] d,
			input logic [TICK_WIDTH-1:0] nominal);
		longint m;
		longint n;
		m = longint'(timing[irpfd_pkg::REG_MARGIN]);
		n = longint'(nominal);
		if (m > n)
			return 1'b0;
		return (longint'(d) > n - m) && (longint'(d) < n + m);
	endfunction

	function automatic irpfd_pkg::result_t make_result(input irpfd_pkg::kind_t k,
			input logic [irpfd_pkg::BITS_PER_BYTE-1:0] v);
		irpfd_pkg::result_t r;
		r.kind     = k;
		r.byte_val = v;
		r.run_last = 1'b0;
		return r;
	endfunction

	// Decode one symbol: update the frame state and queue the results it causes
	function automatic void decode_symbol(input logic [TICK_WIDTH-1:0] hi,
			input logic [TICK_WIDTH-1:0] lo, input logic last);
		irpfd_pkg::result_t caused [$];
		logic               is_one;
		logic               is_zero;
		case (phase)
			irpfd_pkg::PH_LEADER: begin
				if (in_window(hi, timing[irpfd_pkg::REG_LEADER_HIGH]) &&
						in_window(lo, timing[irpfd_pkg::REG_LEADER_LOW])) begin
					phase   = irpfd_pkg::PH_FRAME;
					bit_pos = '0;
					partial = '0;
				end else begin
					caused = {caused, make_result(irpfd_pkg::KIND_ERR, '0)};
					phase  = irpfd_pkg::PH_DONE;
				end
			end
			irpfd_pkg::PH_FRAME: begin
				// stop is tried before a data mark
				if (in_window(hi, timing[irpfd_pkg::REG_STOP_HIGH])) begin
					if (bit_pos == 0)
						caused = {caused, make_result(irpfd_pkg::KIND_OK, '0)};
					else
						caused = {caused, make_result(irpfd_pkg::KIND_ERR, '0)};
					phase = irpfd_pkg::PH_DONE;
				end else if (in_window(hi, timing[irpfd_pkg::REG_BIT_HIGH])) begin
					is_one  = in_window(lo, timing[irpfd_pkg::REG_ONE_LOW]);
					is_zero = in_window(lo, timing[irpfd_pkg::REG_ZERO_LOW]);
					if (!is_one && !is_zero) begin
						caused = {caused, make_result(irpfd_pkg::KIND_ERR, '0)};
						phase  = irpfd_pkg::PH_DONE;
					end else if (bit_pos == irpfd_pkg::BITS_PER_BYTE - 1) begin
						caused  = {caused, make_result(irpfd_pkg::KIND_BYTE, {is_one, partial})};
						bit_pos = '0;
						partial = '0;
					end else begin
						if (is_one)
							partial[bit_pos] = 1'b1;
						bit_pos = bit_pos + 1'b1;
					end
				end else begin
					caused = {caused, make_result(irpfd_pkg::KIND_ERR, '0)};
					phase  = irpfd_pkg::PH_DONE;
				end
			end
			default: ;  // frame ended: ignore until the capture ends
		endcase

		// end of capture: an open frame is an error, then back to leader
		if (last) begin
			if (phase == irpfd_pkg::PH_FRAME)
				caused = {caused, make_result(irpfd_pkg::KIND_ERR, '0)};
			phase   = irpfd_pkg::PH_LEADER;
			bit_pos = '0;
			partial = '0;
		end

		if (caused.size() > 0)
			caused[caused.size() - 1].run_last = 1'b1;
		expected_results = {expected_results, caused};
	endfunction

	// Track writes and symbols, check result beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (timing[i])
				timing[i] = irpfd_pkg::REG_RESET[i][TICK_WIDTH-1:0];
			phase   = irpfd_pkg::PH_LEADER;
			bit_pos = '0;
			partial = '0;
			expected_results.delete();
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < irpfd_pkg::NUM_REGS)
				timing[cfg_index] = cfg_data;

			if (s_tvalid && s_tready) begin
				decode_symbol(s_tdata[TICK_WIDTH-1:0], s_tdata[2*TICK_WIDTH-1:TICK_WIDTH], s_tlast);
				symbols_seen++;
			end

			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with none expected: kind %0d byte %02h last %0b",
						$time, m_tuser, m_tdata, m_tlast);
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.kind) begin
						fail_count++;
						$display("%0t: result_kind expected %0d, actual %0d",
							$time, want.kind, m_tuser);
					end
					if (m_tdata !== want.byte_val) begin
						fail_count++;
						$display("%0t: byte_value expected %02h, actual %02h",
							$time, want.byte_val, m_tdata);
					end
					if (m_tlast !== want.run_last) begin
						fail_count++;
						$display("%0t: run_last expected %0b, actual %0b",
							$time, want.run_last, m_tlast);
					end
				end
				if (m_tuser == irpfd_pkg::KIND_BYTE)
					bytes_seen++;
				else if (m_tuser == irpfd_pkg::KIND_OK)
					oks_seen++;
				else
					errs_seen++;
			end
		end
		pending = expected_results.size();
	end

endmodule

[sim/ir_pulse_frame_decoder_test.sv]
`timescale 1ns / 100ps
// Testbench top for ir_pulse_frame_decoder: clock, reset, symbol frames, register
// writes and result back-pressure; the verdict comes from ir_frame_result_checker.
// Depends on irpfd_pkg, the decoder RTL and ir_frame_result_checker.
module ir_pulse_frame_decoder_test;

	localparam int TW       = 15;
	localparam int S_DATA_W = ((2 * TW + 7) / 8) * 8;
	localparam int MAX_TICK = (1 << TW) - 1;

	// index past the register file; writes to it are dropped
	localparam logic [irpfd_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [7:0] DIRECTED_BYTE = 8'hA5;

	typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_mode_t;
	typedef enum int {
		FR_GOOD, FR_TRUNC, FR_STOP_MID, FR_BAD_MARK, FR_BAD_SPACE, FR_BAD_LEADER, FR_NOISE
	} frame_shape_t;

	typedef struct packed {
		logic [TW-1:0] hi;
		logic [TW-1:0] lo;
	} sym_t;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                s_tvalid  = 1'b0;
	logic                                s_tready;
	logic [S_DATA_W-1:0]                 s_tdata   = '0;
	logic                                s_tlast   = 1'b0;
	logic                                m_tvalid;
	logic                                m_tready  = 1'b0;
	logic [irpfd_pkg::BITS_PER_BYTE-1:0] m_tdata;
	logic [1:0]                          m_tuser;
	logic                                m_tlast;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [irpfd_pkg::REG_IDX_W-1:0]     cfg_index = '0;
	logic [TW-1:0]                       cfg_data  = '0;

	int fail_count, pending, symbols_seen, bytes_seen, oks_seen, errs_seen;

	// Timing values last written, used to shape symbols that hit the windows
	logic [TW-1:0] timing_now [irpfd_pkg::NUM_REGS];
	idle_mode_t    send_idle = IDLE_NONE;
	idle_mode_t    recv_idle = IDLE_NONE;
	int            useful_sent = 0;

	ir_pulse_frame_decoder #(.TICK_WIDTH(TW)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ir_frame_result_checker #(.TICK_WIDTH(TW)) frame_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.symbols_seen (symbols_seen),
		.bytes_seen   (bytes_seen),
		.oks_seen     (oks_seen),
		.errs_seen    (errs_seen)
	);

	always #1 clk = ~clk;

	// Run limit
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int draw_gap(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: return 0;
			IDLE_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 11)) : 0;
			default:   return int'($urandom_range(0, 11));
		endcase
	endfunction

	function automatic logic [TW-1:0] clip_tick(input int v);
		if (v < 0)
			return '0;
		if (v > MAX_TICK)
			return TW'(MAX_TICK);
		return TW'(v);
	endfunction

	function automatic sym_t make_sym(input logic [TW-1:0] hi, input logic [TW-1:0] lo);
		sym_t s;
		s.hi = hi;
		s.lo = lo;
		return s;
	endfunction

	// Values on or one tick inside the window boundary
	function automatic logic [TW-1:0] rim_tick(input logic [TW-1:0] n);
		int m;
		m = int'(timing_now[irpfd_pkg::REG_MARGIN]);
		case ($urandom_range(0, 3))
			0:       return clip_tick(int'(n) - m);
			1:       return clip_tick(int'(n) + m);
			2:       return clip_tick(int'(n) - m + 1);
			default: return clip_tick(int'(n) + m - 1);
		endcase
	endfunction

	function automatic logic [TW-1:0] any_tick();
		return TW'($urandom_range(0, 1) ? $urandom_range(0, MAX_TICK) : $urandom_range(0, 63));
	endfunction

	// Mostly a value inside the window around n, sometimes on its rim
	function automatic logic [TW-1:0] window_pick(input logic [TW-1:0] n);
		int m, lo, hi;
		m  = int'(timing_now[irpfd_pkg::REG_MARGIN]);
		lo = int'(n) - m + 1;
		hi = int'(n) + m - 1;
		if (lo < 0)
			lo = 0;
		if (hi > MAX_TICK)
			hi = MAX_TICK;
		if ($urandom_range(0, 9) == 0)
			return rim_tick(n);
		if (lo > hi)
			return any_tick();
		return TW'($urandom_range(lo, hi));
	endfunction

	function automatic sym_t bit_sym(input logic one);
		return make_sym(window_pick(timing_now[irpfd_pkg::REG_BIT_HIGH]),
			window_pick(one ? timing_now[irpfd_pkg::REG_ONE_LOW]
			                : timing_now[irpfd_pkg::REG_ZERO_LOW]));
	endfunction

	function automatic frame_shape_t pick_shape();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 55) return FR_GOOD;
		if (r < 67) return FR_TRUNC;
		if (r < 75) return FR_STOP_MID;
		if (r < 82) return FR_BAD_MARK;
		if (r < 89) return FR_BAD_SPACE;
		if (r < 95) return FR_BAD_LEADER;
		return FR_NOISE;
	endfunction

	// One symbol beat; data changes at the falling edge
	task automatic send_symbol(input sym_t s, input logic last);
		int gap;
		gap = draw_gap(send_idle);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {{(S_DATA_W - 2 * TW){1'b0}}, s.lo, s.hi};
		s_tlast  <= last;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Hold off symbols until every result is back and the pipe is empty
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_reg(input logic [irpfd_pkg::REG_IDX_W-1:0] idx,
			input logic [TW-1:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx < irpfd_pkg::NUM_REGS)
			timing_now[idx] = val;
	endtask

	task automatic load_timing(input logic [TW-1:0] lead_hi, input logic [TW-1:0] lead_lo,
			input logic [TW-1:0] bit_hi, input logic [TW-1:0] zero_lo,
			input logic [TW-1:0] one_lo, input logic [TW-1:0] stop_hi,
			input logic [TW-1:0] margin);
		wait_drained();
		set_reg(irpfd_pkg::REG_LEADER_HIGH, lead_hi);
		set_reg(irpfd_pkg::REG_LEADER_LOW, lead_lo);
		set_reg(irpfd_pkg::REG_BIT_HIGH, bit_hi);
		set_reg(irpfd_pkg::REG_ZERO_LOW, zero_lo);
		set_reg(irpfd_pkg::REG_ONE_LOW, one_lo);
		set_reg(irpfd_pkg::REG_STOP_HIGH, stop_hi);
		set_reg(irpfd_pkg::REG_MARGIN, margin);
	endtask

	// Build one capture of the given shape and send it, last flag on its final symbol
	task automatic send_frame(input frame_shape_t shape);
		sym_t frame_q [$];
		int   nbits;
		int   trail;
		case (shape)
			FR_GOOD:      nbits = 8 * int'($urandom_range(0, 4));
			FR_TRUNC:     nbits = $urandom_range(0, 1) ? 8 * int'($urandom_range(0, 3))
			                                           : int'($urandom_range(0, 30));
			FR_STOP_MID:  nbits = 8 * int'($urandom_range(0, 2)) + int'($urandom_range(1, 7));
			FR_BAD_MARK,
			FR_BAD_SPACE: nbits = int'($urandom_range(0, 20));
			default:      nbits = 0;
		endcase

		if (shape == FR_NOISE) begin
			repeat ($urandom_range(1, 3)) frame_q = {frame_q, make_sym(any_tick(), any_tick())};
		end else begin
			if (shape == FR_BAD_LEADER)
				frame_q = {frame_q, $urandom_range(0, 1) ? make_sym(any_tick(), any_tick()) :
					make_sym(rim_tick(timing_now[irpfd_pkg::REG_LEADER_HIGH]),
						window_pick(timing_now[irpfd_pkg::REG_LEADER_LOW]))};
			else
				frame_q = {frame_q, make_sym(window_pick(timing_now[irpfd_pkg::REG_LEADER_HIGH]),
					window_pick(timing_now[irpfd_pkg::REG_LEADER_LOW]))};
			repeat (nbits) frame_q = {frame_q, bit_sym(1'($urandom_range(0, 1)))};
			case (shape)
				FR_GOOD, FR_STOP_MID:
					frame_q = {frame_q,
						make_sym(window_pick(timing_now[irpfd_pkg::REG_STOP_HIGH]), any_tick())};
				FR_BAD_MARK:
					frame_q = {frame_q, make_sym($urandom_range(0, 1) ? any_tick() :
						rim_tick($urandom_range(0, 1) ? timing_now[irpfd_pkg::REG_BIT_HIGH]
						                              : timing_now[irpfd_pkg::REG_STOP_HIGH]),
						any_tick())};
				FR_BAD_SPACE:
					frame_q = {frame_q,
						make_sym(window_pick(timing_now[irpfd_pkg::REG_BIT_HIGH]),
						$urandom_range(0, 1) ? any_tick() :
						rim_tick($urandom_range(0, 1) ? timing_now[irpfd_pkg::REG_ONE_LOW]
						                              : timing_now[irpfd_pkg::REG_ZERO_LOW]))};
				default: ;
			endcase
		end

		// symbols after the frame end are ignored and not counted
		useful_sent += frame_q.size();
		trail = (shape == FR_TRUNC || shape == FR_NOISE) ? 0 : int'($urandom_range(0, 2));
		repeat (trail) frame_q = {frame_q, make_sym(any_tick(), any_tick())};

		foreach (frame_q[i])
			send_symbol(frame_q[i], i == frame_q.size() - 1);
	endtask

	task automatic run_random(input int quota);
		int start;
		start = useful_sent;
		while (useful_sent - start < quota) begin
			if ($urandom_range(0, 9) == 0) begin
				send_idle = idle_mode_t'($urandom_range(0, 2));
				recv_idle = idle_mode_t'($urandom_range(0, 2));
			end
			if ($urandom_range(0, 49) == 0)
				wait_drained();
			send_frame(pick_shape());
		end
	endtask

	// Result side back-pressure
	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_gap(recv_idle);
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Main sequence
	initial begin
		foreach (timing_now[i])
			timing_now[i] = irpfd_pkg::REG_RESET[i][TW-1:0];
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset timing: stop and data marks share one window, so stop wins
		send_symbol(make_sym(15'd0, 15'd0), 1'b1);                      // leader mismatch
		send_symbol(make_sym(TW'(MAX_TICK), TW'(MAX_TICK)), 1'b1);      // leader mismatch
		send_symbol(make_sym(15'd9000, 15'd4500), 1'b1);                // leader alone
		send_symbol(make_sym(15'd8801, 15'd4699), 1'b0);
		send_symbol(make_sym(15'd560, 15'd0), 1'b1);                    // stop at boundary
		send_symbol(make_sym(15'd9199, 15'd4301), 1'b0);
		send_symbol(make_sym(15'd761, 15'd560), 1'b1);                  // mark just outside
		send_symbol(make_sym(15'd9000, 15'd4500), 1'b0);
		send_symbol(make_sym(15'd359, 15'd1690), 1'b0);                 // mark just outside
		send_symbol(make_sym(15'd0, 15'd0), 1'b0);                      // ignored
		send_symbol(make_sym(15'd9000, 15'd4500), 1'b1);                // ignored, capture ends

		// Separate stop window, one full byte, then a stop mid-byte
		wait_drained();
		set_reg(irpfd_pkg::REG_STOP_HIGH, 15'd1200);
		set_reg(REG_UNUSED, 15'd0);
		send_symbol(make_sym(15'd9000, 15'd4500), 1'b0);
		for (int i = 0; i < 11; i++)
			send_symbol(make_sym(15'd560, ((i < 8) ? DIRECTED_BYTE[i] : (i < 10)) ?
				15'd1690 : 15'd560), 1'b0);
		send_symbol(make_sym(15'd1200, TW'(MAX_TICK)), 1'b1);

		// Random frames over several timing settings
		send_idle = IDLE_SOME;
		recv_idle = IDLE_FULL;
		run_random(250);

		load_timing(15'd40, 15'd20, 15'd5, 15'd5, 15'd12, 15'd25, 15'd3);
		run_random(250);

		load_timing(TW'(MAX_TICK), 15'd32766, 15'd30000, 15'd20000, 15'd32000, 15'd25000,
			15'd700);
		run_random(250);

		// zero and one windows overlap
		load_timing(15'd9000, 15'd4500, 15'd560, 15'd1000, 15'd1100, 15'd3000, 15'd200);
		run_random(250);

		// margin larger than the zero nominal: zero never matches
		load_timing(15'd9000, 15'd4500, 15'd700, 15'd500, 15'd1690, 15'd2000, 15'd600);
		run_random(250);

		repeat (2) begin
			load_timing(TW'($urandom_range(0, MAX_TICK)), TW'($urandom_range(0, MAX_TICK)),
				TW'($urandom_range(0, 8000)), TW'($urandom_range(0, 8000)),
				TW'($urandom_range(0, 8000)), TW'($urandom_range(0, 8000)),
				TW'($urandom_range(0, 1500)));
			run_random(250);
		end

		load_timing('0, '0, '0, '0, '0, '0, '0);
		run_random(50);

		load_timing(TW'(MAX_TICK), TW'(MAX_TICK), TW'(MAX_TICK), TW'(MAX_TICK),
			TW'(MAX_TICK), TW'(MAX_TICK), TW'(MAX_TICK));
		run_random(50);

		// Drain and let any late beat show up
		wait_drained();
		repeat (8) @(negedge clk);

		$display("Run covered %0d symbols: %0d bytes, %0d good frames, %0d frame errors,",
			symbols_seen, bytes_seen, oks_seen, errs_seen);
		$display("over reset, edge and random timing settings with stalls on both sides.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
sv/irpfd_pkg.sv
sv/irpfd_cfg.sv
sv/irpfd_window.sv
sv/irpfd_core.sv
sv/irpfd_outq.sv
sv/ir_pulse_frame_decoder.sv
sim/ir_frame_result_checker.sv
sim/ir_pulse_frame_decoder_test.sv
